@@ rtl/psum_pkg.sv @@
// ----------------------------------------------------------------------------
// psum_pkg
// Shared constants and types for the prime sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package psum_pkg;

    // default width of the limit n
    localparam int DEF_VALUE_BITS = 12;

    // width of the result field and its saturation value
    localparam int               SUM_BITS = 21;
    localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};

    // status returned by the remainder unit
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder is ready
        logic zero;   // remainder was zero (divisor divides dividend)
    } t_rem_stat;

endpackage

`default_nettype wire

@@ rtl/prime_sum_up_to_n.sv @@
// ----------------------------------------------------------------------------
// prime_sum_up_to_n
// Sum of all primes p with 2 <= p <= n, by trial division.
//
//   channel  dir  handshake               payload
//   in       in   i_in_valid / o_in_stall  i_n          [VALUE_BITS-1:0]
//   out      out  o_out_valid / i_out_stall o_prime_sum [20:0]
//
// One beat in gives one beat out. Each candidate m, from n down to 2, is
// trial-divided by d from 2 upward while d*d <= m in the bit-serial
// remainder unit, stopping at the first d that divides m; a prime then
// takes a closing square test and the add into the sum.
// Reset is synchronous, active low; it idles the sequencer and empties the
// output register. The input is stalled while an item is in work; a new
// beat is taken while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_sum_up_to_n
    import psum_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire logic [VALUE_BITS-1:0] i_n,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      logic [SUM_BITS-1:0]   o_prime_sum
);

    logic                ctl_idle;
    logic                ctl_res_valid;
    logic [SUM_BITS-1:0] ctl_sum;
    logic                res_take;
    logic                in_start;

    logic                r_out_valid;
    logic [SUM_BITS-1:0] r_out_sum;

    assign o_in_stall = !ctl_idle;
    assign in_start   = i_in_valid && ctl_idle;
    // result moves into the output register when it is empty or draining
    assign res_take   = ctl_res_valid && (!r_out_valid || !i_out_stall);

    psum_ctl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_start),
        .i_limit     (i_n),
        .i_res_take  (res_take),
        .o_idle      (ctl_idle),
        .o_res_valid (ctl_res_valid),
        .o_sum       (ctl_sum)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_sum <= ctl_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_prime_sum = r_out_sum;

    // a result is only handed over while the sequencer is busy with it
    a_take_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |-> !ctl_idle)
        else $error("result taken from idle sequencer");

    // an accepted input always starts the sequencer
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_start |=> !ctl_idle)
        else $error("accepted beat did not start work");

    // a taken result fills the output register
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> r_out_valid && (r_out_sum == $past(ctl_sum)))
        else $error("result lost on the way to the output");

endmodule

`default_nettype wire

@@ rtl/psum_rem.sv @@
// ----------------------------------------------------------------------------
// psum_rem
// Shared restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psum_rem
    import psum_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int D_BITS     = (VALUE_BITS + 1) / 2 + 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [D_BITS-1:0]     i_divisor,
    output      t_rem_stat             o_stat
);

    localparam int CNT_BITS = $clog2(VALUE_BITS);

    logic                  r_busy;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [VALUE_BITS-1:0] r_shift;
    logic [D_BITS-1:0]     r_div;
    logic [D_BITS-1:0]     r_rem;
    logic                  r_done;
    logic                  r_zero;

    logic [D_BITS:0]       n_trial;
    logic [D_BITS-1:0]     n_rem;

    // one restoring step: bring down the next bit, subtract if it fits
    always_comb begin
        n_trial = {r_rem, r_shift[VALUE_BITS-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem = D_BITS'(n_trial - {1'b0, r_div});
        end else begin
            n_rem = n_trial[D_BITS-1:0];
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_div   <= i_divisor;
            r_rem   <= '0;
            r_cnt   <= CNT_BITS'(VALUE_BITS - 1);
        end else if (r_busy) begin
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
            r_cnt   <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_zero <= (n_rem == '0);
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;

    // a new divide never starts over a running one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("remainder unit restarted while busy");

    // done follows the last step of a run
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("remainder done without a run");

    // partial remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != CNT_BITS'(VALUE_BITS - 1) |-> r_rem < r_div)
        else $error("partial remainder out of range");

endmodule

`default_nettype wire

@@ rtl/psum_ctl.sv @@
// ----------------------------------------------------------------------------
// psum_ctl
// Sequencer: walks candidates from n down to 2, trial-divides each one
// through the shared remainder unit and accumulates the primes into a saturating sum.
// ----------------------------------------------------------------------------
`default_nettype none

module psum_ctl
    import psum_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_limit,
    input  wire logic                  i_res_take,
    output      logic                  o_idle,
    output      logic                  o_res_valid,
    output      logic [SUM_BITS-1:0]   o_sum
);

    // divisor never passes 2^ceil(VALUE_BITS/2); its square stays below 2^(VALUE_BITS+1)
    localparam int D_BITS  = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS = VALUE_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_TEST,
        S_WAIT,
        S_ADD,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_m;
    logic [D_BITS-1:0]     r_d;
    logic [SQ_BITS-1:0]    r_sq;
    logic [SUM_BITS-1:0]   r_sum;

    logic                  rem_start;
    t_rem_stat             rem_stat;
    logic                  sq_over;
    logic [SUM_BITS:0]     n_sum;

    // shared remainder unit: r_m mod r_d
    psum_rem #(
        .VALUE_BITS (VALUE_BITS),
        .D_BITS     (D_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_m),
        .i_divisor  (r_d),
        .o_stat     (rem_stat)
    );

    // d*d > m ends the trial loop: candidate is prime
    assign sq_over   = r_sq > SQ_BITS'(r_m);
    assign rem_start = (r_state == S_TEST) && !sq_over;
    assign n_sum     = {1'b0, r_sum} + (SUM_BITS + 1)'(r_m);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m     <= i_limit;
                        r_sum   <= '0;
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    if (r_m < VALUE_BITS'(2)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_d     <= D_BITS'(2);
                        r_sq    <= SQ_BITS'(4);
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (sq_over) begin
                        r_state <= S_ADD;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (rem_stat.done) begin
                        if (rem_stat.zero) begin
                            // composite, move to the next candidate
                            r_m     <= r_m - 1'b1;
                            r_state <= S_CAND;
                        end else begin
                            // (d+1)^2 = d^2 + 2d + 1
                            r_sq    <= r_sq + SQ_BITS'({r_d, 1'b0}) + 1'b1;
                            r_d     <= r_d + 1'b1;
                            r_state <= S_TEST;
                        end
                    end
                end
                S_ADD: begin
                    if (n_sum > {1'b0, SUM_MAX}) begin
                        r_sum   <= SUM_MAX;
                        r_state <= S_FIN;
                    end else begin
                        r_sum   <= n_sum[SUM_BITS-1:0];
                        r_m     <= r_m - 1'b1;
                        r_state <= S_CAND;
                    end
                end
                S_FIN: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FIN);
    assign o_sum       = r_sum;

    // a trial division only runs while d*d <= m
    a_trial_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAIT |-> (r_sq <= SQ_BITS'(r_m)) && (r_d >= D_BITS'(2)))
        else $error("trial divisor out of range");

    // remainder results only arrive while waiting for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> r_state == S_WAIT)
        else $error("unexpected remainder result");

    // a candidate below two ends the walk
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CAND && r_m < VALUE_BITS'(2) |=> r_state == S_FIN)
        else $error("candidate walk did not end");

endmodule

`default_nettype wire

@@ dv/prime_sum_up_to_n_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prime_sum_up_to_n_test
// Self-checking bench for the trial-division prime sum block.
//
// A short table of limits (small limits, a few primes and composites, the
// all-ones limit) runs first. Rows whose sum is obvious carry it typed in.
// The rest of the table and a random run of limits are checked against a
// behavioral prime sum. Random limits are mostly small, because the block
// trial-divides every candidate. Both sides idle in short random bursts,
// and the last stretch of the run has no idling.
// ----------------------------------------------------------------------------

module prime_sum_up_to_n_test;
    import psum_pkg::*;

    localparam int N_BITS       = DEF_VALUE_BITS;
    localparam int RANDOM_ITEMS = 100;
    localparam int CALM_ITEMS   = 15;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int ROWS         = 14;

    // one directed row: limit, whether the sum is typed in, and that sum
    typedef struct packed {
        logic [N_BITS-1:0]   lim;
        logic                typed;
        logic [SUM_BITS-1:0] sum;
    } t_plan_row;

    localparam t_plan_row PLAN [ROWS] = '{
        '{12'd0,    1'b1, 21'd0},
        '{12'd1,    1'b1, 21'd0},
        '{12'd2,    1'b1, 21'd2},
        '{12'd3,    1'b1, 21'd5},
        '{12'd4,    1'b0, 21'd0},
        '{12'd10,   1'b1, 21'd17},
        '{12'd11,   1'b0, 21'd0},
        '{12'd1,    1'b1, 21'd0},
        '{12'd25,   1'b0, 21'd0},
        '{12'd49,   1'b0, 21'd0},
        '{12'd97,   1'b0, 21'd0},
        '{12'd0,    1'b1, 21'd0},
        '{12'd4095, 1'b0, 21'd0},
        '{12'd13,   1'b0, 21'd0}
    };

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [N_BITS-1:0]   i_n         = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [SUM_BITS-1:0] o_prime_sum;

    logic [SUM_BITS-1:0] sums_due [$];
    logic [SUM_BITS-1:0] sum_want;
    int unsigned         mismatches = 0;
    int unsigned         cycles     = 0;
    int unsigned         stall_left = 0;
    bit                  calm       = 1'b0;

    prime_sum_up_to_n #(
        .VALUE_BITS (N_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_n         (i_n),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_prime_sum (o_prime_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sum of every prime up to lim, saturating at the result width
    function automatic logic [SUM_BITS-1:0] sum_primes_upto(input logic [N_BITS-1:0] lim);
        int unsigned total;
        int unsigned m;
        int unsigned d;
        bit          prime;
        total = 0;
        for (m = 2; m <= lim; m++) begin
            prime = 1'b1;
            for (d = 2; d * d <= m; d++) begin
                if (m % d == 0) begin
                    prime = 1'b0;
                    break;
                end
            end
            if (prime) begin
                total += m;
                if (total > SUM_MAX) begin
                    total = SUM_MAX;
                    break;
                end
            end
        end
        return total[SUM_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycles, what);
        mismatches++;
    endtask

    // drive one limit and hold it until the block takes the beat
    task automatic send_limit(input logic [N_BITS-1:0] lim, input logic [SUM_BITS-1:0] sum);
        i_in_valid <= 1'b1;
        i_n        <= lim;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sums_due.push_back(sum);
    endtask

    // random sender gap, none in the calm stretch
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_sums();
        while (sums_due.size() != 0) @(posedge i_clk);
    endtask

    // output stall: random bursts, none in the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker and run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("prime_sum_up_to_n regression: fail");
            $finish;
        end else if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (sums_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, prime_sum %0d", o_prime_sum));
            end else begin
                sum_want = sums_due.pop_front();
                if (o_prime_sum !== sum_want)
                    report_mismatch($sformatf("prime_sum %0d, want %0d",
                                              o_prime_sum, sum_want));
            end
        end
    end

    // stimulus
    initial begin
        int unsigned       k;
        int unsigned       pick;
        logic [N_BITS-1:0] lim;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (k = 0; k < ROWS; k++) begin
            send_limit(PLAN[k].lim,
                       PLAN[k].typed ? PLAN[k].sum : sum_primes_upto(PLAN[k].lim));
            sender_gap();
        end

        // hold off until the block has drained
        i_in_valid <= 1'b0;
        wait_all_sums();
        @(posedge i_clk);

        // random limits, mostly small to keep the run short
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            pick = $urandom_range(0, 15);
            if (pick == 0)
                lim = N_BITS'($urandom_range(128, 600));
            else if (pick < 4)
                lim = N_BITS'($urandom_range(0, 3));
            else
                lim = N_BITS'($urandom_range(0, 90));
            send_limit(lim, sum_primes_upto(lim));
            sender_gap();
        end

        i_in_valid <= 1'b0;
        wait_all_sums();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("prime_sum_up_to_n regression: pass");
        else
            $display("prime_sum_up_to_n regression: fail");
        $finish;
    end

endmodule
